>>> rtl/gcycd_pkg.sv
package gcycd_pkg;

   // Fixed field widths
   localparam int NODE_W = 6;
   localparam int CNT_W  = 7;
   localparam int OP_W   = 2;
   localparam int STAT_W = 2;
   localparam int EDGE_W = 2 * NODE_W;
   localparam int COL_W  = 2;

   // Default sizes
   localparam int MAX_NODES_DEF = 64;
   localparam int MAX_EDGES_DEF = 4096;

   // Request opcodes
   localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
   localparam logic [OP_W-1:0] OP_MARK  = 2'd1;
   localparam logic [OP_W-1:0] OP_CHECK = 2'd2;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

   // Response status codes
   localparam logic [STAT_W-1:0] ST_NONE   = 2'd0;
   localparam logic [STAT_W-1:0] ST_MEMBER = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

   // Search colors
   localparam logic [COL_W-1:0] COL_WHITE = 2'd0;
   localparam logic [COL_W-1:0] COL_GREY  = 2'd1;
   localparam logic [COL_W-1:0] COL_BLACK = 2'd2;

endpackage

>>> rtl/graph_cycle_detector_core.sv
// Channel | Dir | Ports                                  | Beat
// --------+-----+----------------------------------------+-----------------------------------
// csr     | in  | csr_valid/ready, csr_node_count        | one write of the node count
// req     | in  | req_valid/ready, req_op/from/to_node   | add edge, mark root, check, clear
// rsp     | out | rsp_valid/ready, rsp_status/node/last  | verdict, cycle member, store full
//
// Add, mark and clear beats are taken in idle and may arrive back to back while the response is free.
// A check runs on one sequencer over color, stack and edge memories with one read and one write port:
// a sweep of every color entry, then per root tried a color lookup, a scan of the stored edges per level
// with a color lookup per matching edge, pops, and a stack scan that emits the path entries.
// Synchronous active-high reset; edge, color, stack and cursor memories are not cleared.
// The response register holds its beat while rsp_ready is low; the search waits on it.
module graph_cycle_detector_core #(
   parameter int MAX_NODES = gcycd_pkg::MAX_NODES_DEF,
   parameter int MAX_EDGES = gcycd_pkg::MAX_EDGES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [gcycd_pkg::CNT_W-1:0]  csr_node_count,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [gcycd_pkg::OP_W-1:0]   req_op,
   input  logic [gcycd_pkg::NODE_W-1:0] req_from_node,
   input  logic [gcycd_pkg::NODE_W-1:0] req_to_node,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [gcycd_pkg::STAT_W-1:0] rsp_status,
   output logic [gcycd_pkg::NODE_W-1:0] rsp_node,
   output logic                         rsp_last
);
   import gcycd_pkg::*;

   // Node indices never exceed the node field, so per-node storage stops there
   localparam int NODES   = (MAX_NODES < (1 << NODE_W)) ? MAX_NODES : (1 << NODE_W);
   localparam int SADDR_W = $clog2(NODES);
   localparam int DEPTH_W = $clog2(NODES + 1);
   localparam int ECNT_W  = $clog2(MAX_EDGES + 1);
   localparam int EADDR_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

   // Sequencer states
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_CLR      = 4'd1;
   localparam logic [3:0] S_ROOT_RD  = 4'd2;
   localparam logic [3:0] S_ROOT_CK  = 4'd3;
   localparam logic [3:0] S_EDGE_RD  = 4'd4;
   localparam logic [3:0] S_EDGE_CK  = 4'd5;
   localparam logic [3:0] S_COLOR_CK = 4'd6;
   localparam logic [3:0] S_POP_LD   = 4'd7;
   localparam logic [3:0] S_SCAN_RD  = 4'd8;
   localparam logic [3:0] S_SCAN_CK  = 4'd9;
   localparam logic [3:0] S_EMIT_RD  = 4'd10;
   localparam logic [3:0] S_EMIT_WR  = 4'd11;
   localparam logic [3:0] S_VERD     = 4'd12;

   logic [3:0]         state_ff, state_in;
   logic [CNT_W-1:0]   ncount_ff;
   logic [ECNT_W-1:0]  ecnt_ff, ecnt_in;
   logic [NODES-1:0]   root_ff, root_in;
   logic [DEPTH_W-1:0] dep_ff, dep_in;
   logic [DEPTH_W-1:0] rt_ff, rt_in;
   logic [DEPTH_W-1:0] idx_ff, idx_in;
   logic [NODE_W-1:0]  top_ff, top_in;
   logic [NODE_W-1:0]  tgt_ff, tgt_in;
   logic [ECNT_W-1:0]  cur_ff, cur_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [NODE_W-1:0]  rsp_node_ff, rsp_node_in;
   logic               rsp_last_ff, rsp_last_in;

   // Memory ports
   logic [EDGE_W-1:0]  edge_mem [MAX_EDGES];
   logic               edge_we, edge_re;
   logic [EADDR_W-1:0] edge_wa, edge_ra;
   logic [EDGE_W-1:0]  edge_wd, edge_rd_ff;

   logic [COL_W-1:0]   col_mem [NODES];
   logic               col_we, col_re;
   logic [SADDR_W-1:0] col_wa, col_ra;
   logic [COL_W-1:0]   col_wd, col_rd_ff;

   logic [NODE_W-1:0]  stk_mem [NODES];
   logic [ECNT_W-1:0]  cur_mem [NODES];
   logic               stk_we, cur_we, stk_re;
   logic [SADDR_W-1:0] stk_wa, cur_wa, stk_ra;
   logic [NODE_W-1:0]  stk_wd, stk_rd_ff;
   logic [ECNT_W-1:0]  cur_wd, cur_rd_ff;

   logic               req_fire, out_free, from_ok, to_ok;
   logic [CNT_W-1:0]   lim;
   logic [NODE_W-1:0]  ef, et;

   // Handshakes
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == S_IDLE) && out_free;
   assign req_fire   = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_node   = rsp_node_ff;
   assign rsp_last   = rsp_last_ff;

   // Effective node count and range checks
   assign lim     = (ncount_ff < CNT_W'(NODES)) ? ncount_ff : CNT_W'(NODES);
   assign from_ok = CNT_W'(req_from_node) < lim;
   assign to_ok   = CNT_W'(req_to_node) < lim;
   assign ef      = edge_rd_ff[EDGE_W-1:NODE_W];
   assign et      = edge_rd_ff[NODE_W-1:0];

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      ecnt_in       = ecnt_ff;
      root_in       = root_ff;
      dep_in        = dep_ff;
      rt_in         = rt_ff;
      idx_in        = idx_ff;
      top_in        = top_ff;
      tgt_in        = tgt_ff;
      cur_in        = cur_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_node_in   = rsp_node_ff;
      rsp_last_in   = rsp_last_ff;
      edge_we = 1'b0;
      edge_wa = ecnt_ff[EADDR_W-1:0];
      edge_wd = {req_from_node, req_to_node};
      edge_re = 1'b0;
      edge_ra = cur_ff[EADDR_W-1:0];
      col_we  = 1'b0;
      col_wa  = idx_ff[SADDR_W-1:0];
      col_wd  = COL_WHITE;
      col_re  = 1'b0;
      col_ra  = rt_ff[SADDR_W-1:0];
      stk_we  = 1'b0;
      stk_wa  = dep_ff[SADDR_W-1:0];
      stk_wd  = tgt_ff;
      cur_we  = 1'b0;
      cur_wa  = SADDR_W'(dep_ff - DEPTH_W'(1));
      cur_wd  = cur_ff;
      stk_re  = 1'b0;
      stk_ra  = idx_ff[SADDR_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_op)
                  OP_ADD: begin
                     if (from_ok && to_ok) begin
                        if (ecnt_ff >= ECNT_W'(MAX_EDGES)) begin
                           rsp_valid_in  = 1'b1;
                           rsp_status_in = ST_FULL;
                           rsp_node_in   = '0;
                           rsp_last_in   = 1'b1;
                        end else begin
                           edge_we = 1'b1;
                           ecnt_in = ecnt_ff + ECNT_W'(1);
                        end
                     end
                  end
                  OP_MARK: begin
                     if (from_ok) begin
                        root_in[req_from_node[SADDR_W-1:0]] = 1'b1;
                     end
                  end
                  OP_CHECK: begin
                     idx_in   = '0;
                     state_in = S_CLR;
                  end
                  OP_CLEAR: begin
                     ecnt_in = '0;
                     root_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         // Sweep every color entry back to white
         S_CLR: begin
            col_we = 1'b1;
            if (idx_ff == DEPTH_W'(NODES - 1)) begin
               rt_in    = '0;
               state_in = S_ROOT_RD;
            end else begin
               idx_in = idx_ff + DEPTH_W'(1);
            end
         end
         // Next root candidate
         S_ROOT_RD: begin
            if (CNT_W'(rt_ff) >= lim) begin
               state_in = S_VERD;
            end else begin
               col_re   = 1'b1;
               state_in = S_ROOT_CK;
            end
         end
         S_ROOT_CK: begin
            if (root_ff[rt_ff[SADDR_W-1:0]] && col_rd_ff == COL_WHITE) begin
               col_we   = 1'b1;
               col_wa   = rt_ff[SADDR_W-1:0];
               col_wd   = COL_GREY;
               stk_we   = 1'b1;
               stk_wa   = '0;
               stk_wd   = NODE_W'(rt_ff);
               top_in   = NODE_W'(rt_ff);
               cur_in   = '0;
               dep_in   = DEPTH_W'(1);
               state_in = S_EDGE_RD;
            end else begin
               rt_in    = rt_ff + DEPTH_W'(1);
               state_in = S_ROOT_RD;
            end
         end
         // Fetch the next edge of the top node, or pop when exhausted
         S_EDGE_RD: begin
            if (cur_ff >= ecnt_ff) begin
               col_we = 1'b1;
               col_wa = top_ff[SADDR_W-1:0];
               col_wd = COL_BLACK;
               dep_in = dep_ff - DEPTH_W'(1);
               if (dep_ff == DEPTH_W'(1)) begin
                  rt_in    = rt_ff + DEPTH_W'(1);
                  state_in = S_ROOT_RD;
               end else begin
                  stk_re   = 1'b1;
                  stk_ra   = SADDR_W'(dep_ff - DEPTH_W'(2));
                  state_in = S_POP_LD;
               end
            end else begin
               edge_re  = 1'b1;
               cur_in   = cur_ff + ECNT_W'(1);
               state_in = S_EDGE_CK;
            end
         end
         S_EDGE_CK: begin
            if (ef == top_ff && CNT_W'(ef) < lim && CNT_W'(et) < lim) begin
               col_re   = 1'b1;
               col_ra   = et[SADDR_W-1:0];
               tgt_in   = et;
               state_in = S_COLOR_CK;
            end else begin
               state_in = S_EDGE_RD;
            end
         end
         S_COLOR_CK: begin
            case (col_rd_ff)
               COL_GREY: begin
                  idx_in   = '0;
                  state_in = S_SCAN_RD;
               end
               COL_WHITE: begin
                  // Save this level's cursor, push the target
                  cur_we   = 1'b1;
                  stk_we   = 1'b1;
                  col_we   = 1'b1;
                  col_wa   = tgt_ff[SADDR_W-1:0];
                  col_wd   = COL_GREY;
                  top_in   = tgt_ff;
                  cur_in   = '0;
                  dep_in   = dep_ff + DEPTH_W'(1);
                  state_in = S_EDGE_RD;
               end
               default: begin
                  state_in = S_EDGE_RD;
               end
            endcase
         end
         S_POP_LD: begin
            top_in   = stk_rd_ff;
            cur_in   = cur_rd_ff;
            state_in = S_EDGE_RD;
         end
         // Find the first path entry of the back edge target
         S_SCAN_RD: begin
            stk_re   = 1'b1;
            state_in = S_SCAN_CK;
         end
         S_SCAN_CK: begin
            if (stk_rd_ff == tgt_ff) begin
               state_in = S_EMIT_RD;
            end else begin
               idx_in   = idx_ff + DEPTH_W'(1);
               state_in = S_SCAN_RD;
            end
         end
         // Emit path entries through the top
         S_EMIT_RD: begin
            stk_re   = 1'b1;
            state_in = S_EMIT_WR;
         end
         S_EMIT_WR: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_MEMBER;
               rsp_node_in   = stk_rd_ff;
               rsp_last_in   = (idx_ff + DEPTH_W'(1)) == dep_ff;
               if ((idx_ff + DEPTH_W'(1)) == dep_ff) begin
                  dep_in   = '0;
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + DEPTH_W'(1);
                  state_in = S_EMIT_RD;
               end
            end
         end
         S_VERD: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_NONE;
               rsp_node_in   = '0;
               rsp_last_in   = 1'b1;
               dep_in        = '0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ncount_ff    <= '0;
         ecnt_ff      <= '0;
         root_ff      <= '0;
         dep_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ecnt_ff      <= ecnt_in;
         root_ff      <= root_in;
         dep_ff       <= dep_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            ncount_ff <= csr_node_count;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      rt_ff         <= rt_in;
      idx_ff        <= idx_in;
      top_ff        <= top_in;
      tgt_ff        <= tgt_in;
      cur_ff        <= cur_in;
      rsp_status_ff <= rsp_status_in;
      rsp_node_ff   <= rsp_node_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Edge store
   always_ff @(posedge clock) begin
      if (edge_we) begin
         edge_mem[edge_wa] <= edge_wd;
      end
      if (edge_re) begin
         edge_rd_ff <= edge_mem[edge_ra];
      end
   end

   // Node colors
   always_ff @(posedge clock) begin
      if (col_we) begin
         col_mem[col_wa] <= col_wd;
      end
      if (col_re) begin
         col_rd_ff <= col_mem[col_ra];
      end
   end

   // Path stack and per-level edge cursors
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_wa] <= stk_wd;
      end
      if (cur_we) begin
         cur_mem[cur_wa] <= cur_wd;
      end
      if (stk_re) begin
         stk_rd_ff <= stk_mem[stk_ra];
         cur_rd_ff <= cur_mem[stk_ra];
      end
   end

endmodule

>>> rtl/gcycd_checker.sv
module gcycd_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic [gcycd_pkg::OP_W-1:0]   req_op,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [gcycd_pkg::STAT_W-1:0] rsp_status,
   input logic [gcycd_pkg::NODE_W-1:0] rsp_node,
   input logic                         rsp_last
);
   import gcycd_pkg::*;

   // A stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_node)
         && $stable(rsp_last))
      else $error("response beat changed while stalled");

   // Only defined status codes appear
   a_rsp_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_NONE || rsp_status == ST_MEMBER || rsp_status == ST_FULL))
      else $error("undefined response status");

   // Verdict and store-full beats are single and carry node zero
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_MEMBER |-> rsp_last && rsp_node == '0)
      else $error("non-member beat without last or with a node");

   // A check keeps the block busy on the next cycle
   a_check_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_op == OP_CHECK |=> !req_ready)
      else $error("request taken right after a check");

endmodule

bind graph_cycle_detector_core gcycd_checker u_gcycd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_ready  (req_ready),
   .req_op     (req_op),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_status (rsp_status),
   .rsp_node   (rsp_node),
   .rsp_last   (rsp_last)
);
